>>> rtl/video_raster_irq_registers_core_macros.svh
// assertion macros shared by the raster irq checker
// no dependencies; pulled in by the checker file
`ifndef VIDEO_RASTER_IRQ_REGISTERS_CORE_MACROS_SVH
`define VIDEO_RASTER_IRQ_REGISTERS_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define VRIRQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define VRIRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/vrirq_pkg.sv
// types, codes and chip model tables for the raster irq register block
// no dependencies; used by the store, core and checker files of the block
package vrirq_pkg;

    // request opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // register addresses
    localparam logic [7:0] ADDR_RASTER_HI   = 8'h11;
    localparam logic [7:0] ADDR_RASTER_LO   = 8'h12;
    localparam logic [7:0] ADDR_IRQ_FLAGS   = 8'h19;
    localparam logic [7:0] ADDR_IRQ_MASK    = 8'h1a;
    localparam logic [7:0] ADDR_LAST_STORED = 8'h2e;
    localparam logic [7:0] ADDR_LAST_REG    = 8'h3f;

    // chip models
    localparam logic [1:0] MODEL_262_LINES = 2'd0;
    localparam logic [1:0] MODEL_263_LINES = 2'd1;
    localparam logic [1:0] MODEL_312_LINES = 2'd2;

    localparam int         DEF_REG_COUNT  = 64;
    localparam logic [1:0] DEF_CHIP_MODEL = MODEL_312_LINES;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] addr;
        logic [7:0] wdata;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_out;
    } t_out_item;

    // cycles in one raster line
    function automatic logic [6:0] cycles_per_line(input logic [1:0] model);
        logic [6:0] res;
        case (model)
            MODEL_262_LINES: res = 7'd64;
            MODEL_263_LINES: res = 7'd65;
            default:         res = 7'd63;
        endcase
        return res;
    endfunction

    // raster lines in one frame
    function automatic logic [8:0] lines_per_frame(input logic [1:0] model);
        logic [8:0] res;
        case (model)
            MODEL_262_LINES: res = 9'd262;
            MODEL_263_LINES: res = 9'd263;
            default:         res = 9'd312;
        endcase
        return res;
    endfunction

endpackage

>>> rtl/vrirq_store.sv
// byte register store with per-entry valid bits and write-to-read bypass
// depends on vrirq_pkg
module vrirq_store import vrirq_pkg::*; #(
    parameter int REG_COUNT = DEF_REG_COUNT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [$clog2(REG_COUNT)-1:0] i_wr_addr,
    input  logic [7:0]                   i_wr_data,
    input  logic                         i_rd_en,
    input  logic [$clog2(REG_COUNT)-1:0] i_rd_addr,
    output logic [7:0]                   o_rd_data
);

    logic [7:0]           r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    logic [7:0]           r_q;
    logic                 r_q_valid;
    logic                 r_fwd;
    logic [7:0]           r_fwd_data;

    // storage array, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    // valid bits stand in for the cleared reset contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_valid <= r_valid[i_rd_addr];
                r_fwd     <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    // bypass data for a read that meets a write of the same entry
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : (r_q_valid ? r_q : 8'h00);

endmodule

>>> rtl/video_raster_irq_registers_core.sv
// raster counter with raster-compare interrupt behind a 64-address register bus
// accepted requests are held in the stage register, then results in the result register
// throughput: one request per cycle unless the output stalls; both registers form the pipe
// reset (synchronous, active low): model 312 lines, counters at the last cycle and line,
// flags, mask and compare cleared; store entries read zero via valid bits, no clearing pass
// depends on vrirq_pkg and vrirq_store
module video_raster_irq_registers_core import vrirq_pkg::*; #(
    parameter int REG_COUNT = DEF_REG_COUNT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    localparam int AW = $clog2(REG_COUNT);
    localparam logic [7:0] STORE_END = 8'(REG_COUNT);

    logic [1:0] r_chip_model;
    logic       r_s1_valid;
    t_in_item   r_s1;
    logic       r_out_valid;
    t_out_item  r_out;
    logic [6:0] r_line_cycle;
    logic [8:0] r_line_number;
    logic [8:0] r_compare;
    logic [3:0] r_flag_low;
    logic       r_flag_req;
    logic [3:0] r_mask;

    logic [6:0] n_line_cycle;
    logic [8:0] n_line_number;
    logic [8:0] n_compare;
    logic [3:0] n_flag_low;
    logic       n_flag_req;
    logic [3:0] n_mask;
    t_out_item  n_out;

    logic       in_accept;
    logic       s1_adv;
    logic       in_store_in;
    logic       s1_in_store;
    logic [7:0] store_rd;
    logic [6:0] cpl;
    logic [8:0] lpf;
    logic [6:0] cyc_inc;
    logic [8:0] line_inc;
    logic [3:0] low_tmp;
    logic [7:0] rd;

    // handshake
    assign s1_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !s1_adv;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign in_store_in = i_in_data.addr < STORE_END;
    assign s1_in_store = r_s1.addr < STORE_END;

    // register store
    vrirq_store #(
        .REG_COUNT (REG_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (s1_adv && (r_s1.opcode == OP_WRITE) && s1_in_store),
        .i_wr_addr (r_s1.addr[AW-1:0]),
        .i_wr_data (r_s1.wdata),
        .i_rd_en   (in_accept),
        .i_rd_addr (in_store_in ? i_in_data.addr[AW-1:0] : AW'(0)),
        .o_rd_data (store_rd)
    );

    assign cpl      = cycles_per_line(r_chip_model);
    assign lpf      = lines_per_frame(r_chip_model);
    assign cyc_inc  = r_line_cycle + 7'd1;
    assign line_inc = r_line_number + 9'd1;

    // read mux
    always_comb begin
        if (r_s1.addr > ADDR_LAST_REG) begin
            rd = 8'h00;
        end else if (r_s1.addr > ADDR_LAST_STORED) begin
            rd = 8'hff;
        end else begin
            case (r_s1.addr)
                ADDR_RASTER_HI: rd = {r_line_number[8], 7'd0};
                ADDR_RASTER_LO: rd = r_line_number[7:0];
                ADDR_IRQ_FLAGS: rd = {r_flag_req, 3'd0, r_flag_low};
                ADDR_IRQ_MASK:  rd = {4'hf, r_mask};
                default:        rd = s1_in_store ? store_rd : 8'h00;
            endcase
        end
    end

    // request execution
    always_comb begin
        n_line_cycle  = r_line_cycle;
        n_line_number = r_line_number;
        n_compare     = r_compare;
        n_flag_low    = r_flag_low;
        n_flag_req    = r_flag_req;
        n_mask        = r_mask;
        low_tmp       = 4'd0;
        n_out.read_data = 8'h00;
        case (r_s1.opcode)
            OP_TICK: begin
                if (cyc_inc >= cpl) begin
                    n_line_cycle  = 7'd0;
                    n_line_number = (line_inc >= lpf) ? 9'd0 : line_inc;
                end else begin
                    n_line_cycle = cyc_inc;
                end
                // raster compare hit at the first cycle of the line
                if ((n_line_cycle == 7'd0) && (r_compare < lpf)
                    && (n_line_number == r_compare)) begin
                    n_flag_low = r_flag_low | 4'b0001;
                    if ((r_mask & n_flag_low) != 4'd0) begin
                        n_flag_req = 1'b1;
                    end
                end
            end
            OP_READ: begin
                n_out.read_data = rd;
            end
            OP_WRITE: begin
                case (r_s1.addr)
                    ADDR_RASTER_HI: n_compare[8] = r_s1.wdata[7];
                    ADDR_RASTER_LO: n_compare[7:0] = r_s1.wdata;
                    ADDR_IRQ_FLAGS: begin
                        // acknowledge; request drops once no flag is left
                        low_tmp    = r_flag_low & ~r_s1.wdata[3:0];
                        n_flag_low = low_tmp;
                        n_flag_req = r_flag_req && (low_tmp != 4'd0);
                    end
                    ADDR_IRQ_MASK: begin
                        n_mask = r_s1.wdata[3:0];
                        if ((r_s1.wdata[3:0] & r_flag_low) == 4'd0) begin
                            n_flag_low = 4'd0;
                            n_flag_req = 1'b0;
                        end else begin
                            n_flag_req = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        n_out.irq_out = n_flag_req;
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_model  <= DEF_CHIP_MODEL;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_line_cycle  <= cycles_per_line(DEF_CHIP_MODEL) - 7'd1;
            r_line_number <= lines_per_frame(DEF_CHIP_MODEL) - 9'd1;
            r_compare     <= 9'd0;
            r_flag_low    <= 4'd0;
            r_flag_req    <= 1'b0;
            r_mask        <= 4'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_chip_model <= i_cfg_data;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid   <= 1'b1;
                r_line_cycle  <= n_line_cycle;
                r_line_number <= n_line_number;
                r_compare     <= n_compare;
                r_flag_low    <= n_flag_low;
                r_flag_req    <= n_flag_req;
                r_mask        <= n_mask;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= i_in_data;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

endmodule

>>> rtl/vrirq_checker.sv
// port-level checks for the raster irq register block, bound to the top level
// depends on vrirq_pkg and video_raster_irq_registers_core_macros.svh
`include "video_raster_irq_registers_core_macros.svh"

module vrirq_checker import vrirq_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input t_in_item   i_in_data,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input t_out_item  o_out_data,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic [1:0] i_cfg_data
);

    // a pending result stays offered while stalled
    `VRIRQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")

    // input side only backs up when the output side is stalled
    `VRIRQ_ASSERT_NOW(a_in_stall_cause, i_clk, i_rst_n, o_in_stall, i_out_stall && o_out_valid, "input stalled without output backpressure")

    // an accepted request passes through the stage register to a valid result unless the output is stalled
    `VRIRQ_ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_in_valid && !o_in_stall) ##1 !i_out_stall, o_out_valid, "result missing after accepted request")

endmodule

bind video_raster_irq_registers_core vrirq_checker u_vrirq_checker (.*);
